>>> hdl/scte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scte_pkg;

	localparam int NUM_SPANS_DEF   = 64;
	localparam int BLOCK_BYTES_DEF = 4096;
	localparam int MAX_LEN_DEF     = 1048575;

	localparam int OP_W   = 2;
	localparam int OFF_W  = 32;
	localparam int LEN_W  = 20;
	localparam int END_W  = 33;
	localparam int ST_W   = 3;
	localparam int SLOT_W = 6;
	localparam int MLEN_W = 21;
	localparam int DOFF_W = 21;
	localparam int RCNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_REQ  = 2'd0,
		OP_DROP = 2'd1,
		OP_FAIL = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_HIT   = 3'd0,
		ST_MISS  = 3'd1,
		ST_WB    = 3'd2,
		ST_CLEAN = 3'd3,
		ST_BUSY  = 3'd4,
		ST_NOACT = 3'd5,
		ST_FAIL  = 3'd6,
		ST_RANGE = 3'd7
	} status_t;

	typedef struct packed {
		logic    latch;
		logic    scan_start;
		logic    scan;
		logic    hit_take;
		logic    alloc;
		logic    rd_active;
		logic    clr_active;
		logic    free_active;
		logic    res_load;
		status_t res_status;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            active;
		logic            range_bad;
		logic            dirty;
		logic            hit;
		logic            last;
		logic            out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hdl/scte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module scte_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  scte_pkg::sts_t      sts,
	output scte_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_ALLOC,
		S_WBRES,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					scte_pkg::OP_REQ: begin
						if (sts.active) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = scte_pkg::ST_BUSY;
							state_d        = S_FIN;
						end else if (sts.range_bad) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = scte_pkg::ST_RANGE;
							state_d        = S_FIN;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					scte_pkg::OP_DROP: begin
						if (!sts.active) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = scte_pkg::ST_NOACT;
							state_d        = S_FIN;
						end else if (sts.dirty) begin
							cmd.rd_active = 1'b1;
							state_d       = S_WBRES;
						end else begin
							cmd.res_load   = 1'b1;
							cmd.res_status = scte_pkg::ST_CLEAN;
							cmd.clr_active = 1'b1;
							state_d        = S_FIN;
						end
					end
					scte_pkg::OP_FAIL: begin
						cmd.res_load = 1'b1;
						if (!sts.active) begin
							cmd.res_status = scte_pkg::ST_NOACT;
						end else begin
							cmd.res_status  = scte_pkg::ST_FAIL;
							cmd.free_active = 1'b1;
						end
						state_d = S_FIN;
					end
					default: begin
						// unused op: no result
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.hit_take   = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_status = scte_pkg::ST_HIT;
					state_d        = S_FIN;
				end else if (sts.last) begin
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.alloc      = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = scte_pkg::ST_MISS;
				state_d        = S_FIN;
			end
			S_WBRES: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = scte_pkg::ST_WB;
				cmd.clr_active = 1'b1;
				state_d        = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_stall <= 1'b0;
		end else begin
			state_q  <= state_d;
			in_stall <= (state_d != S_IDLE);
		end
	end

endmodule

`default_nettype wire

>>> hdl/scte_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module scte_dpath #(
	parameter int NUM_SPANS   = scte_pkg::NUM_SPANS_DEF,
	parameter int BLOCK_BYTES = scte_pkg::BLOCK_BYTES_DEF,
	parameter int MAX_LEN     = scte_pkg::MAX_LEN_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  scte_pkg::cmd_t                    cmd,
	output scte_pkg::sts_t                    sts,
	input  wire  [scte_pkg::OP_W-1:0]         op,
	input  wire  [scte_pkg::OFF_W-1:0]        offset,
	input  wire  [scte_pkg::LEN_W-1:0]        length,
	input  wire                               dirty,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [scte_pkg::ST_W-1:0]         status,
	output logic [scte_pkg::SLOT_W-1:0]       slot,
	output logic [scte_pkg::OFF_W-1:0]        mem_start,
	output logic [scte_pkg::MLEN_W-1:0]       mem_len,
	output logic [scte_pkg::DOFF_W-1:0]       data_offset,
	output logic [scte_pkg::RCNT_W-1:0]       removed_count
);

	localparam int IW     = (NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 1;
	localparam int RW     = $clog2(NUM_SPANS + 1);
	localparam int OW     = scte_pkg::OFF_W;
	localparam int EW     = scte_pkg::END_W;
	localparam int MW     = EW + OW;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SPANS - 1);
	localparam logic [EW-1:0] MASK_E   = EW'(BLOCK_BYTES - 1);
	localparam logic [OW-1:0] MASK_O   = OW'(BLOCK_BYTES - 1);

	// latched item
	logic [scte_pkg::OP_W-1:0]  op_q;
	logic [OW-1:0]              off_q;
	logic [scte_pkg::LEN_W-1:0] len_q;
	logic                       dirty_q;
	logic [EW-1:0]              end_q;

	// tag store
	logic [MW-1:0]        mem [NUM_SPANS];
	logic [MW-1:0]        rd_data_q;
	logic [IW-1:0]        rd_addr;
	logic [NUM_SPANS-1:0] valid_q;

	// scan
	logic [IW-1:0] rd_cnt_q;
	logic          rd_more_q;
	logic          act_s1;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [RW-1:0] removed_q;
	logic          free_found_q;
	logic [IW-1:0] free_slot_q;
	logic [IW-1:0] victim_q;

	logic          act_q;
	logic [IW-1:0] act_slot_q;

	// result staging
	logic [scte_pkg::ST_W-1:0]   res_status_q;
	logic [scte_pkg::SLOT_W-1:0] res_slot_q;
	logic [OW-1:0]               res_start_q;
	logic [scte_pkg::MLEN_W-1:0] res_len_q;
	logic [scte_pkg::DOFF_W-1:0] res_doff_q;
	logic [scte_pkg::RCNT_W-1:0] res_rcnt_q;

	logic [OW-1:0] rd_begin;
	logic [EW-1:0] rd_limit;
	logic [EW-1:0] b_e;
	logic [EW-1:0] off_e;
	logic          hit_c;
	logic          inval_c;
	logic          kill;
	logic          post_vld;
	logic [IW-1:0] alloc_slot;
	logic [OW-1:0] new_begin;
	logic [EW-1:0] new_limit;
	logic [EW-1:0] wb_len;
	logic [EW-1:0] miss_len;
	logic [OW-1:0] hit_doff;
	logic          range_bad;

	assign rd_begin = rd_data_q[OW-1:0];
	assign rd_limit = rd_data_q[MW-1:OW];
	assign b_e      = {1'b0, rd_begin};
	assign off_e    = {1'b0, off_q};

	assign hit_c   = (b_e <= off_e) && (end_q <= rd_limit);
	assign inval_c = ((b_e <= off_e) && (off_e < rd_limit)) ||
	                 ((b_e <= end_q) && (end_q < rd_limit));
	assign kill     = act_s1 && vld_s1 && !hit_c && inval_c;
	assign post_vld = vld_s1 && !kill;

	assign alloc_slot = free_found_q ? free_slot_q : victim_q;
	assign new_begin  = off_q & ~MASK_O;
	assign new_limit  = (end_q + MASK_E) & ~MASK_E;
	assign miss_len   = new_limit - {1'b0, new_begin};
	assign wb_len     = rd_limit - b_e;
	assign hit_doff   = off_q - rd_begin;

	assign range_bad = (32'(len_q) > 32'(MAX_LEN)) || (end_q[EW-1] && (|end_q[EW-2:0]));

	assign rd_addr = cmd.rd_active ? act_slot_q : rd_cnt_q;

	always_comb begin
		sts           = '0;
		sts.op        = op_q;
		sts.active    = act_q;
		sts.range_bad = range_bad;
		sts.dirty     = dirty_q;
		sts.hit       = act_s1 && vld_s1 && hit_c;
		sts.last      = act_s1 && (idx_s1 == LAST_IDX);
		sts.out_free  = !out_valid || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			off_q   <= offset;
			len_q   <= length;
			dirty_q <= dirty;
			end_q   <= {1'b0, offset} + EW'(length);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			mem[alloc_slot] <= {new_limit, new_begin};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q     <= '0;
			rd_more_q    <= 1'b0;
			act_s1       <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			removed_q    <= '0;
			free_found_q <= 1'b0;
			free_slot_q  <= '0;
		end else if (cmd.scan_start) begin
			rd_cnt_q     <= '0;
			rd_more_q    <= 1'b1;
			act_s1       <= 1'b0;
			removed_q    <= '0;
			free_found_q <= 1'b0;
		end else if (cmd.scan) begin
			act_s1 <= rd_more_q;
			if (rd_more_q) begin
				idx_s1    <= rd_cnt_q;
				vld_s1    <= valid_q[rd_cnt_q];
				rd_cnt_q  <= IW'(rd_cnt_q + 1'b1);
				rd_more_q <= (rd_cnt_q != LAST_IDX);
			end
			if (kill) begin
				removed_q <= RW'(removed_q + 1'b1);
			end
			// first slot left free once this one has been checked
			if (act_s1 && !post_vld && !free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			victim_q   <= '0;
			act_q      <= 1'b0;
			act_slot_q <= '0;
		end else begin
			if (cmd.scan && kill) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.free_active) begin
				valid_q[act_slot_q] <= 1'b0;
			end
			if (cmd.alloc) begin
				valid_q[alloc_slot] <= 1'b1;
				act_q               <= 1'b1;
				act_slot_q          <= alloc_slot;
				if (!free_found_q) begin
					victim_q <= (victim_q == LAST_IDX) ? '0 : IW'(victim_q + 1'b1);
				end
			end
			if (cmd.hit_take) begin
				act_q      <= 1'b1;
				act_slot_q <= idx_s1;
			end
			if (cmd.clr_active || cmd.free_active) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_status)
				scte_pkg::ST_HIT: begin
					res_slot_q  <= scte_pkg::SLOT_W'(idx_s1);
					res_start_q <= '0;
					res_len_q   <= '0;
					res_doff_q  <= scte_pkg::DOFF_W'(hit_doff);
					res_rcnt_q  <= scte_pkg::RCNT_W'(removed_q);
				end
				scte_pkg::ST_MISS: begin
					res_slot_q  <= scte_pkg::SLOT_W'(alloc_slot);
					res_start_q <= new_begin;
					res_len_q   <= scte_pkg::MLEN_W'(miss_len);
					res_doff_q  <= scte_pkg::DOFF_W'(off_q & MASK_O);
					res_rcnt_q  <= scte_pkg::RCNT_W'(removed_q);
				end
				scte_pkg::ST_WB: begin
					res_slot_q  <= scte_pkg::SLOT_W'(act_slot_q);
					res_start_q <= rd_begin;
					res_len_q   <= scte_pkg::MLEN_W'(wb_len);
					res_doff_q  <= '0;
					res_rcnt_q  <= '0;
				end
				scte_pkg::ST_CLEAN,
				scte_pkg::ST_FAIL: begin
					res_slot_q  <= scte_pkg::SLOT_W'(act_slot_q);
					res_start_q <= '0;
					res_len_q   <= '0;
					res_doff_q  <= '0;
					res_rcnt_q  <= '0;
				end
				default: begin
					res_slot_q  <= '0;
					res_start_q <= '0;
					res_len_q   <= '0;
					res_doff_q  <= '0;
					res_rcnt_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status        <= res_status_q;
			slot          <= res_slot_q;
			mem_start     <= res_start_q;
			mem_len       <= res_len_q;
			data_offset   <= res_doff_q;
			removed_count <= res_rcnt_q;
		end
	end

`ifndef ASSERT_OFF
	a_alloc_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |=> act_q && valid_q[act_slot_q])
		else $error("allocated slot not left valid and active");

	a_free_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc && free_found_q |-> !valid_q[free_slot_q])
		else $error("free slot chosen while still valid");

	a_fail_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_active |=> !act_q && !valid_q[$past(act_slot_q)])
		else $error("fetch failure did not free the active slot");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || !out_stall))
		else $error("result overwrites an item not yet taken");
`endif

endmodule

`default_nettype wire

>>> hdl/span_cache_tag_engine_core.sv
// Steps: a missing request scans every slot (one slot per cycle through the tag memory read
//   port), then allocates; a hit in slot i ends the scan there. Busy and range rejects, clean
//   drops and fetch failures go from decode straight to the result; dirty drops read the tag first.
// Items are taken one at a time, and an unused op returns to idle with no result;
//   the next item is taken while the previous result waits in the output register.
// Reset: valid bits, active span, victim pointer and handshake clear at once; no tag clear.
`timescale 1ns / 1ps
`default_nettype none

module span_cache_tag_engine_core #(
	parameter int NUM_SPANS   = scte_pkg::NUM_SPANS_DEF,
	parameter int BLOCK_BYTES = scte_pkg::BLOCK_BYTES_DEF,
	parameter int MAX_LEN     = scte_pkg::MAX_LEN_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [scte_pkg::OP_W-1:0]         op,
	input  wire  [scte_pkg::OFF_W-1:0]        offset,
	input  wire  [scte_pkg::LEN_W-1:0]        length,
	input  wire                               dirty,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [scte_pkg::ST_W-1:0]         status,
	output logic [scte_pkg::SLOT_W-1:0]       slot,
	output logic [scte_pkg::OFF_W-1:0]        mem_start,
	output logic [scte_pkg::MLEN_W-1:0]       mem_len,
	output logic [scte_pkg::DOFF_W-1:0]       data_offset,
	output logic [scte_pkg::RCNT_W-1:0]       removed_count
);

	scte_pkg::cmd_t cmd;
	scte_pkg::sts_t sts;

	scte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	scte_dpath #(
		.NUM_SPANS   (NUM_SPANS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.MAX_LEN     (MAX_LEN)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.offset        (offset),
		.length        (length),
		.dirty         (dirty),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot          (slot),
		.mem_start     (mem_start),
		.mem_len       (mem_len),
		.data_offset   (data_offset),
		.removed_count (removed_count)
	);

endmodule

`default_nettype wire

>>> tb/span_tag_check.sv
`timescale 1ns / 1ps

module span_tag_check (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  op,
	input  wire  [31:0] offset,
	input  wire  [19:0] length,
	input  wire         dirty,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [2:0]  status,
	input  wire  [5:0]  slot,
	input  wire  [31:0] mem_start,
	input  wire  [20:0] mem_len,
	input  wire  [20:0] data_offset,
	input  wire  [6:0]  removed_count,
	output int          mismatches,
	output int          awaited
);
	import scte_pkg::*;

	localparam int          SPANS    = NUM_SPANS_DEF;
	localparam logic [32:0] ALIGN    = 33'(BLOCK_BYTES_DEF - 1);
	localparam logic [32:0] ADDR_TOP = 33'h1_0000_0000;

	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
		logic [31:0] start;
		logic [20:0] len;
		logic [20:0] doff;
		logic [6:0]  removed;
	} span_result_t;

	logic [31:0]  span_lo [SPANS];
	logic [32:0]  span_hi [SPANS];
	logic         span_live [SPANS];
	int           victim;
	logic         busy_span;
	int           busy_slot;
	span_result_t due_q [$];

	task automatic tag_lookup(input logic [1:0] o, input logic [31:0] a, input logic [19:0] n,
			input logic d, output bit has, output span_result_t r);
		logic [32:0] stop;
		logic [32:0] span_len;
		logic [31:0] rel;
		int          pick;
		int          removed;
		bit          hit;
		r = '0;
		has = 1'b1;
		case (o)
			OP_REQ: begin
				stop = {1'b0, a} + {13'd0, n};
				if (busy_span) begin
					r.status = ST_BUSY;
				end else if (n > MAX_LEN_DEF || stop > ADDR_TOP) begin
					r.status = ST_RANGE;
				end else begin
					hit = 1'b0;
					removed = 0;
					for (int i = 0; i < SPANS && !hit; i++) begin
						if (span_live[i]) begin
							if (span_lo[i] <= a && stop <= span_hi[i]) begin
								hit = 1'b1;
								busy_span = 1'b1;
								busy_slot = i;
								rel = a - span_lo[i];
								r.status = ST_HIT;
								r.slot = i[5:0];
								r.doff = rel[20:0];
								r.removed = removed[6:0];
							end else if ((span_lo[i] <= a && {1'b0, a} < span_hi[i]) ||
									({1'b0, span_lo[i]} <= stop && stop < span_hi[i])) begin
								span_live[i] = 1'b0;
								removed++;
							end
						end
					end
					if (!hit) begin
						pick = -1;
						for (int i = 0; i < SPANS && pick < 0; i++)
							if (!span_live[i])
								pick = i;
						if (pick < 0) begin
							pick = victim;
							victim = (victim == SPANS - 1) ? 0 : victim + 1;
						end
						span_lo[pick] = a & ~ALIGN[31:0];
						span_hi[pick] = (stop + ALIGN) & ~ALIGN;
						span_live[pick] = 1'b1;
						busy_span = 1'b1;
						busy_slot = pick;
						span_len = span_hi[pick] - {1'b0, span_lo[pick]};
						rel = a - span_lo[pick];
						r.status = ST_MISS;
						r.slot = pick[5:0];
						r.start = span_lo[pick];
						r.len = span_len[20:0];
						r.doff = rel[20:0];
						r.removed = removed[6:0];
					end
				end
			end
			OP_DROP: begin
				if (!busy_span) begin
					r.status = ST_NOACT;
				end else begin
					busy_span = 1'b0;
					r.slot = busy_slot[5:0];
					if (d) begin
						span_len = span_hi[busy_slot] - {1'b0, span_lo[busy_slot]};
						r.status = ST_WB;
						r.start = span_lo[busy_slot];
						r.len = span_len[20:0];
					end else begin
						r.status = ST_CLEAN;
					end
				end
			end
			OP_FAIL: begin
				if (!busy_span) begin
					r.status = ST_NOACT;
				end else begin
					span_live[busy_slot] = 1'b0;
					busy_span = 1'b0;
					r.status = ST_FAIL;
					r.slot = busy_slot[5:0];
				end
			end
			default: has = 1'b0;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		span_result_t want;
		span_result_t got;
		bit           has;
		if (!arst_n) begin
			for (int i = 0; i < SPANS; i++) begin
				span_lo[i] = '0;
				span_hi[i] = '0;
				span_live[i] = 1'b0;
			end
			victim = 0;
			busy_span = 1'b0;
			busy_slot = 0;
			due_q.delete();
			mismatches = 0;
			awaited <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {status_t'(status), slot, mem_start, mem_len, data_offset, removed_count};
				if (due_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: st=%0d slot=%0d start=%h len=%h doff=%h rem=%0d",
							got.status, got.slot, got.start, got.len, got.doff, got.removed);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					if (got != want) begin
						if (mismatches < 10)
							$display("mismatch: want st=%0d slot=%0d start=%h len=%h doff=%h rem=%0d, got st=%0d slot=%0d start=%h len=%h doff=%h rem=%0d",
								want.status, want.slot, want.start, want.len, want.doff,
								want.removed, got.status, got.slot, got.start, got.len,
								got.doff, got.removed);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				tag_lookup(op, offset, length, dirty, has, want);
				if (has)
					due_q.push_back(want);
			end
			awaited <= due_q.size();
		end
	end

endmodule

>>> tb/span_cache_tag_engine_core_tb.sv
`timescale 1ns / 1ps

module span_cache_tag_engine_core_tb;

	localparam int         N_ITEMS    = 1250;
	localparam int         CALM_ITEMS = 150;
	localparam int         LIMIT      = 1000000;
	localparam logic [1:0] OP_SPARE   = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [31:0] offset;
	logic [19:0] length;
	logic        dirty;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic [31:0] mem_start;
	logic [20:0] mem_len;
	logic [20:0] data_offset;
	logic [6:0]  removed_count;

	int mismatches;
	int awaited;
	int cycles;
	int sent;
	bit calm;
	bit gaps_on;
	bit stalls_on;

	span_cache_tag_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .offset(offset), .length(length), .dirty(dirty),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .slot(slot), .mem_start(mem_start), .mem_len(mem_len),
		.data_offset(data_offset), .removed_count(removed_count)
	);

	span_tag_check chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .offset(offset), .length(length), .dirty(dirty),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .slot(slot), .mem_start(mem_start), .mem_len(mem_len),
		.data_offset(data_offset), .removed_count(removed_count),
		.mismatches(mismatches), .awaited(awaited)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side back-pressure, in bursts, with quiet stretches
	initial begin
		out_stall = 1'b0;
		stalls_on = 1'b1;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				stalls_on = !stalls_on;
			if (!calm && stalls_on && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_item(input logic [1:0] o, input logic [31:0] a, input logic [19:0] n,
			input logic d);
		@(negedge clk);
		if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		offset = a;
		length = n;
		dirty = d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (o != OP_SPARE)
			sent++;
	endtask

	// mostly local ranges so that hits and partial overlaps occur, strided ones
	// to fill every slot, and some near the top of the address space
	task automatic pick_range(output logic [31:0] a, output logic [19:0] n);
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 45) begin
			a = $urandom_range(0, 32'h3FFFF);
			n = 20'($urandom_range(0, 20000));
		end else if (mode < 75) begin
			a = ($urandom_range(0, 127) << 16) + $urandom_range(0, 8191);
			n = 20'($urandom_range(0, 8192));
		end else if (mode < 85) begin
			a = 32'hFFFF_FFFF - $urandom_range(0, 32'h20_0000);
			n = 20'($urandom_range(0, 20'hFFFFF));
		end else begin
			a = $urandom();
			n = 20'($urandom());
		end
	endtask

	initial begin
		logic [31:0] a;
		logic [19:0] n;
		int          pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = scte_pkg::OP_REQ;
		offset = '0;
		length = '0;
		dirty = 1'b0;
		sent = 0;
		calm = 1'b0;
		gaps_on = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// idle drops and failures, spare op code, empty and top-of-space spans
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b1);
		send_item(scte_pkg::OP_FAIL, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
		send_item(OP_SPARE, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
		send_item(scte_pkg::OP_REQ, 32'd0, 20'd0, 1'b0);
		send_item(scte_pkg::OP_REQ, 32'd100, 20'd50, 1'b0);
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b1);
		send_item(scte_pkg::OP_REQ, 32'd100, 20'd50, 1'b0);
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b0);
		send_item(scte_pkg::OP_REQ, 32'd200, 20'd100, 1'b0);
		send_item(scte_pkg::OP_FAIL, 32'd0, 20'd0, 1'b0);
		send_item(scte_pkg::OP_REQ, 32'hFFFF_F000, 20'd4096, 1'b0);
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b1);
		send_item(scte_pkg::OP_REQ, 32'hFFFF_FFFF, 20'd1, 1'b0);
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b1);
		send_item(scte_pkg::OP_REQ, 32'hFFFF_FFFF, 20'd2, 1'b0);
		send_item(scte_pkg::OP_REQ, 32'd0, 20'hFFFFF, 1'b0);
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b1);
		send_item(scte_pkg::OP_REQ, 32'h000F_FFF0, 20'h20, 1'b0);
		send_item(scte_pkg::OP_DROP, 32'd0, 20'd0, 1'b0);
		send_item(scte_pkg::OP_REQ, 32'h0000_0FF0, 20'h20, 1'b0);
		send_item(scte_pkg::OP_FAIL, 32'd0, 20'd0, 1'b1);

		while (sent < N_ITEMS) begin
			if (sent >= N_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if ($urandom_range(0, 49) == 0)
				gaps_on = !gaps_on;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				pick_range(a, n);
				send_item(scte_pkg::OP_REQ, a, n, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 9) == 0) begin
					pick_range(a, n);
					send_item($urandom_range(0, 1) ? scte_pkg::OP_REQ : OP_SPARE, a, n,
						1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 4) == 0)
					send_item(scte_pkg::OP_FAIL, $urandom(), 20'($urandom()),
						1'($urandom_range(0, 1)));
				else
					send_item(scte_pkg::OP_DROP, $urandom(), 20'($urandom()),
						1'($urandom_range(0, 1)));
			end else if (pick < 92) begin
				send_item($urandom_range(0, 1) ? scte_pkg::OP_DROP : scte_pkg::OP_FAIL,
					$urandom(), 20'($urandom()), 1'($urandom_range(0, 1)));
			end else begin
				send_item(OP_SPARE, $urandom(), 20'($urandom()), 1'($urandom_range(0, 1)));
			end
			// a full drain after each pass that ends just past the halfway mark
			if (sent >= N_ITEMS / 2 && sent < N_ITEMS / 2 + 3) begin
				@(negedge clk);
				in_valid = 1'b0;
				do @(negedge clk); while (awaited != 0);
			end
		end
		@(negedge clk);
		in_valid = 1'b0;
		do @(negedge clk); while (awaited != 0);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
